// ===== rtl/core/crs_pkg.sv =====
`timescale 1ns / 1ps

package crs_pkg;

    localparam int EnergyW    = 22;
    localparam int SumW       = 36;
    localparam int CountW     = 16;
    localparam int CatW       = 4;
    localparam int NumCats    = 10;
    localparam int NumThr     = 5;
    localparam int CfgIdxW    = 3;
    localparam int QueueDepth = 2;

    // Classes in priority-chain order; a class number is also the index of its
    // threshold register, and category = 2 * class + (minus side).
    typedef enum logic [CfgIdxW-1:0] {
        CLS_FWD_HAD = 3'd0,
        CLS_END_HAD = 3'd1,
        CLS_BAR_HAD = 3'd2,
        CLS_END_EM  = 3'd3,
        CLS_BAR_EM  = 3'd4
    } cls_e;

    // One classified tower as it travels from the front to the back.
    typedef struct packed {
        logic [NumCats-1:0]        hit;
        logic signed [EnergyW-1:0] energy;
        logic signed [EnergyW-1:0] transverse;
        logic                      last;
    } tower_word_t;

endpackage

// ===== rtl/core/crs_intf.sv =====
`timescale 1ns / 1ps

interface crs_tower_if;
    logic                                valid;
    logic                                ready;
    logic                                has_forward_hadron;
    logic                                has_endcap_hadron;
    logic                                has_barrel_hadron;
    logic                                has_endcap_em;
    logic                                has_barrel_em;
    logic                                plus_side;
    logic signed [crs_pkg::EnergyW-1:0]  tower_energy;
    logic signed [crs_pkg::EnergyW-1:0]  tower_transverse;
    logic                                last_tower;

    modport source (
        output valid, has_forward_hadron, has_endcap_hadron, has_barrel_hadron,
               has_endcap_em, has_barrel_em, plus_side, tower_energy,
               tower_transverse, last_tower,
        input  ready
    );
    modport sink (
        input  valid, has_forward_hadron, has_endcap_hadron, has_barrel_hadron,
               has_endcap_em, has_barrel_em, plus_side, tower_energy,
               tower_transverse, last_tower,
        output ready
    );
endinterface

interface crs_result_if;
    logic                               valid;
    logic                               ready;
    logic [crs_pkg::CatW-1:0]           category;
    logic [crs_pkg::CountW-1:0]         tower_count;
    logic signed [crs_pkg::SumW-1:0]    energy_sum;
    logic signed [crs_pkg::SumW-1:0]    transverse_sum;
    logic                               last_result;

    modport source (
        output valid, category, tower_count, energy_sum, transverse_sum, last_result,
        input  ready
    );
    modport sink (
        input  valid, category, tower_count, energy_sum, transverse_sum, last_result,
        output ready
    );
endinterface

interface crs_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [crs_pkg::CfgIdxW-1:0]        index;
    logic [crs_pkg::EnergyW-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/crs_front.sv =====
`timescale 1ns / 1ps

module crs_front (
    input  logic                  clk,
    input  logic                  rst_n,
    crs_tower_if.sink             tower,
    crs_cfg_if.sink               cfg,
    output logic                  push_valid,
    input  logic                  push_ready,
    output crs_pkg::tower_word_t  push_word
);

    logic signed [crs_pkg::EnergyW-1:0] thr_reg [crs_pkg::NumThr];

    logic                had_sel;
    crs_pkg::cls_e       had_cls;
    logic                em_sel;
    crs_pkg::cls_e       em_cls;
    logic [crs_pkg::NumCats-1:0] hit;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < crs_pkg::NumThr; i++)
            begin
                thr_reg[i] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                crs_pkg::CLS_FWD_HAD: thr_reg[crs_pkg::CLS_FWD_HAD] <= cfg.data;
                crs_pkg::CLS_END_HAD: thr_reg[crs_pkg::CLS_END_HAD] <= cfg.data;
                crs_pkg::CLS_BAR_HAD: thr_reg[crs_pkg::CLS_BAR_HAD] <= cfg.data;
                crs_pkg::CLS_END_EM:  thr_reg[crs_pkg::CLS_END_EM]  <= cfg.data;
                crs_pkg::CLS_BAR_EM:  thr_reg[crs_pkg::CLS_BAR_EM]  <= cfg.data;
                default: ;
            endcase
        end
    end

    // Hadronic and electromagnetic priority chains. A tower may feed one class
    // of each kind.
    always_comb
    begin
        had_sel = 1'b1;
        had_cls = crs_pkg::CLS_FWD_HAD;
        priority if (tower.has_forward_hadron && !tower.has_endcap_hadron)
            had_cls = crs_pkg::CLS_FWD_HAD;
        else if (tower.has_endcap_hadron && !tower.has_forward_hadron
                 && !tower.has_barrel_hadron)
            had_cls = crs_pkg::CLS_END_HAD;
        else if (tower.has_barrel_hadron && !tower.has_endcap_hadron)
            had_cls = crs_pkg::CLS_BAR_HAD;
        else
            had_sel = 1'b0;

        em_sel = 1'b1;
        em_cls = crs_pkg::CLS_END_EM;
        priority if (tower.has_endcap_em && !tower.has_barrel_em)
            em_cls = crs_pkg::CLS_END_EM;
        else if (tower.has_barrel_em && !tower.has_endcap_em)
            em_cls = crs_pkg::CLS_BAR_EM;
        else
            em_sel = 1'b0;

        hit = '0;
        if (had_sel && (tower.tower_energy >= thr_reg[had_cls]))
            hit[{had_cls, ~tower.plus_side}] = 1'b1;
        if (em_sel && (tower.tower_energy >= thr_reg[em_cls]))
            hit[{em_cls, ~tower.plus_side}] = 1'b1;
    end

    assign tower.ready           = push_ready;
    assign push_valid            = tower.valid;
    assign push_word.hit         = hit;
    assign push_word.energy      = tower.tower_energy;
    assign push_word.transverse  = tower.tower_transverse;
    assign push_word.last        = tower.last_tower;

endmodule

// ===== rtl/core/crs_queue.sv =====
`timescale 1ns / 1ps

module crs_queue #(
    parameter int DEPTH = crs_pkg::QueueDepth
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  crs_pkg::tower_word_t  push_word,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output crs_pkg::tower_word_t  pop_word
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    crs_pkg::tower_word_t mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            push, pop;

    assign push_ready = (count_reg != CntW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_word   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

endmodule

// ===== rtl/core/crs_back.sv =====
`timescale 1ns / 1ps

module crs_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  crs_pkg::tower_word_t  pop_word,
    crs_result_if.source          result
);

    localparam int N    = crs_pkg::NumCats;
    localparam int RptW = $clog2(crs_pkg::NumCats + 1);

    function automatic logic signed [crs_pkg::SumW-1:0] sat_add(
        input logic signed [crs_pkg::SumW-1:0]    acc,
        input logic signed [crs_pkg::EnergyW-1:0] val
    );
        logic [crs_pkg::SumW:0] s;
        s = {acc[crs_pkg::SumW-1], acc}
          + {{(crs_pkg::SumW + 1 - crs_pkg::EnergyW){val[crs_pkg::EnergyW-1]}}, val};
        if (s[crs_pkg::SumW] != s[crs_pkg::SumW-1])
            return s[crs_pkg::SumW] ? {1'b1, {(crs_pkg::SumW-1){1'b0}}}
                                    : {1'b0, {(crs_pkg::SumW-1){1'b1}}};
        return s[crs_pkg::SumW-1:0];
    endfunction

    // One accumulator lane per category, plus a report buffer that shifts
    // toward its head, which drives the result word.
    logic [crs_pkg::CountW-1:0]      cnt_reg  [N];
    logic [crs_pkg::CountW-1:0]      cnt_next [N];
    logic signed [crs_pkg::SumW-1:0] esum_reg  [N];
    logic signed [crs_pkg::SumW-1:0] esum_next [N];
    logic signed [crs_pkg::SumW-1:0] tsum_reg  [N];
    logic signed [crs_pkg::SumW-1:0] tsum_next [N];

    logic [crs_pkg::CountW-1:0]      upd_cnt  [N];
    logic signed [crs_pkg::SumW-1:0] upd_esum [N];
    logic signed [crs_pkg::SumW-1:0] upd_tsum [N];

    logic [crs_pkg::CountW-1:0]      rpt_cnt_reg  [N];
    logic [crs_pkg::CountW-1:0]      rpt_cnt_next [N];
    logic signed [crs_pkg::SumW-1:0] rpt_esum_reg  [N];
    logic signed [crs_pkg::SumW-1:0] rpt_esum_next [N];
    logic signed [crs_pkg::SumW-1:0] rpt_tsum_reg  [N];
    logic signed [crs_pkg::SumW-1:0] rpt_tsum_next [N];
    logic [RptW-1:0]                 rpt_left_reg, rpt_left_next;

    logic rpt_free, pop, load, out_fire;

    // The report buffer can take a new event when it is empty or is handing
    // over its last word in this cycle.
    assign rpt_free  = (rpt_left_reg == '0)
                     || ((rpt_left_reg == RptW'(1)) && result.ready);
    assign pop_ready = !pop_word.last || rpt_free;
    assign pop       = pop_valid && pop_ready;
    assign load      = pop && pop_word.last;
    assign out_fire  = result.valid && result.ready;

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            upd_cnt[k]  = cnt_reg[k];
            upd_esum[k] = esum_reg[k];
            upd_tsum[k] = tsum_reg[k];
            if (pop_word.hit[k])
            begin
                upd_cnt[k]  = (&cnt_reg[k]) ? cnt_reg[k] : cnt_reg[k] + 1'b1;
                upd_esum[k] = sat_add(esum_reg[k], pop_word.energy);
                upd_tsum[k] = sat_add(tsum_reg[k], pop_word.transverse);
            end

            cnt_next[k]  = cnt_reg[k];
            esum_next[k] = esum_reg[k];
            tsum_next[k] = tsum_reg[k];
            if (load)
            begin
                cnt_next[k]  = '0;
                esum_next[k] = '0;
                tsum_next[k] = '0;
            end
            else if (pop)
            begin
                cnt_next[k]  = upd_cnt[k];
                esum_next[k] = upd_esum[k];
                tsum_next[k] = upd_tsum[k];
            end

            rpt_cnt_next[k]  = rpt_cnt_reg[k];
            rpt_esum_next[k] = rpt_esum_reg[k];
            rpt_tsum_next[k] = rpt_tsum_reg[k];
            if (load)
            begin
                rpt_cnt_next[k]  = upd_cnt[k];
                rpt_esum_next[k] = upd_esum[k];
                rpt_tsum_next[k] = upd_tsum[k];
            end
            else if (out_fire && (k < N - 1))
            begin
                rpt_cnt_next[k]  = rpt_cnt_reg[(k + 1) % N];
                rpt_esum_next[k] = rpt_esum_reg[(k + 1) % N];
                rpt_tsum_next[k] = rpt_tsum_reg[(k + 1) % N];
            end
        end

        rpt_left_next = rpt_left_reg;
        if (load)
            rpt_left_next = RptW'(N);
        else if (out_fire)
            rpt_left_next = rpt_left_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                cnt_reg[k]  <= '0;
                esum_reg[k] <= '0;
                tsum_reg[k] <= '0;
            end
            rpt_left_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                cnt_reg[k]  <= cnt_next[k];
                esum_reg[k] <= esum_next[k];
                tsum_reg[k] <= tsum_next[k];
            end
            rpt_left_reg <= rpt_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            rpt_cnt_reg[k]  <= rpt_cnt_next[k];
            rpt_esum_reg[k] <= rpt_esum_next[k];
            rpt_tsum_reg[k] <= rpt_tsum_next[k];
        end
    end

    assign result.valid          = (rpt_left_reg != '0);
    assign result.category       = crs_pkg::CatW'(N) - crs_pkg::CatW'(rpt_left_reg);
    assign result.tower_count    = rpt_cnt_reg[0];
    assign result.energy_sum     = rpt_esum_reg[0];
    assign result.transverse_sum = rpt_tsum_reg[0];
    assign result.last_result    = (rpt_left_reg == RptW'(1));

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ((rpt_left_reg == '0) || ((rpt_left_reg == RptW'(1)) && out_fire)))
        else $error("report loaded while previous report still pending");

    a_report_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (result.valid && (result.category == '0)))
        else $error("report did not start with the first category");

    a_report_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && result.last_result && !load) |=> !result.valid)
        else $error("result still offered after the final word of a report");

    a_lanes_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> ((cnt_reg[0] == '0) && (esum_reg[N-1] == '0)))
        else $error("accumulators not cleared after a report");

endmodule

// ===== rtl/core/calo_tower_region_summer_unit.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Word contents
// tower    in   presence flags, plus_side, tower_energy, tower_transverse, last_tower
// result   out  category, tower_count, energy_sum, transverse_sum, last_result
// cfg      in   index (threshold register 0..4), data (22-bit signed threshold)
//
// One tower is taken every cycle while the queue has room; a tower is written
// into the queue by the classify stage and reaches the accumulator lanes when popped.
// A last tower moves all ten lane values into the report buffer, which sends
// one word per cycle while result is ready, ten words in all, as new towers keep accumulating.
// A second last tower waits in the queue until the report buffer is free.
// Reset clears thresholds, lanes and the queue at once; no clearing pass.
// cfg is always ready; writes to indexes above 4 are dropped.
module calo_tower_region_summer_unit #(
    parameter int QUEUE_DEPTH = crs_pkg::QueueDepth
) (
    input  logic          clk,
    input  logic          rst_n,
    crs_tower_if.sink     tower,
    crs_result_if.source  result,
    crs_cfg_if.sink       cfg
);

    logic                 push_valid, push_ready;
    crs_pkg::tower_word_t push_word;
    logic                 pop_valid, pop_ready;
    crs_pkg::tower_word_t pop_word;

    crs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tower      (tower),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    crs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    crs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_word  (pop_word),
        .result    (result)
    );

endmodule
